// ===== sv/bha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bha_pkg
// Types, codes and default sizes shared by the bucketed hash accumulator table.
// ----------------------------------------------------------------------------
package bha_pkg;

  localparam int BUCKET_BITS_DEF      = 10;
  localparam int SLOTS_PER_BUCKET_DEF = 16;

  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_GET = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_MERGED   = 3'd1,
    ST_FULL     = 3'd2,
    ST_FOUND    = 3'd3,
    ST_MISSING  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    FILL,
    SCAN,
    RESOLVE
  } state_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] key;
    logic [31:0] inc_a;
    logic [31:0] inc_b;
    logic [31:0] inc_c;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] value_a;
    logic [31:0] value_b;
    logic [31:0] value_c;
    logic [63:0] adds_seen;
    logic [63:0] keys_stored;
  } rsp_t;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] count_a;
    logic [31:0] count_b;
    logic [31:0] count_c;
  } slot_t;

endpackage

// ===== sv/bucketed_hash_accumulator_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucketed_hash_accumulator_table
// Hash table of 64-bit keys with three wrapping 32-bit counters per slot.
// A request runs through a bucket fill read, one slot read per cycle over the
// filled slots of the bucket, and a write-back step that waits while the result
// is stalled; a hit ends the scan early. One request in flight at a time.
// Reset: a clearing pass zeroes the bucket fill memory, during which no request
// is taken. Slot memory is not cleared.
// ----------------------------------------------------------------------------
module bucketed_hash_accumulator_table
  import bha_pkg::*;
#(
  parameter int BUCKET_BITS      = BUCKET_BITS_DEF,
  parameter int SLOTS_PER_BUCKET = SLOTS_PER_BUCKET_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp_data
);

  localparam int     NUM_BUCKETS = 1 << BUCKET_BITS;
  localparam int     FILL_W      = $clog2(SLOTS_PER_BUCKET + 1);
  localparam longint NUM_SLOTS   = longint'(NUM_BUCKETS) * longint'(SLOTS_PER_BUCKET);
  localparam int     ADDR_W      = $clog2(NUM_SLOTS);

  localparam logic [ADDR_W-1:0] SPB_A = ADDR_W'(SLOTS_PER_BUCKET);
  localparam logic [FILL_W-1:0] SPB_F = FILL_W'(SLOTS_PER_BUCKET);

  // Memories
  logic [FILL_W-1:0] fill_mem [NUM_BUCKETS];
  slot_t             slot_mem [NUM_SLOTS];

  state_t state, state_next;

  req_t                   req_q;
  logic [BUCKET_BITS-1:0] bucket;
  logic [ADDR_W-1:0]      base;
  logic [FILL_W-1:0]      fill_q;
  logic [FILL_W-1:0]      scan_idx;
  logic                   cmp_vld;
  logic [ADDR_W-1:0]      cmp_addr;
  slot_t                  slot_q;
  logic                   hit;
  logic [ADDR_W-1:0]      hit_addr;
  slot_t                  hit_data;
  logic [63:0]            add_total;
  logic [63:0]            unique_total;
  logic [BUCKET_BITS-1:0] clr_idx;
  rsp_t                   rsp_q;

  // Control outputs
  logic                   fill_re;
  logic                   fill_we;
  logic [BUCKET_BITS-1:0] fill_waddr;
  logic [FILL_W-1:0]      fill_wdata;
  logic                   slot_re;
  logic [ADDR_W-1:0]      slot_raddr;
  logic                   slot_we;
  logic [ADDR_W-1:0]      slot_waddr;
  slot_t                  slot_wdata;
  logic                   load;
  logic                   cmp_hit;
  logic                   scan_done;
  logic                   is_add;
  logic                   full;
  logic                   do_insert;
  rsp_t                   rsp_next;

  assign bucket     = req_q.key[63 -: BUCKET_BITS];
  assign slot_raddr = base + ADDR_W'(scan_idx);
  assign cmp_hit    = cmp_vld && (slot_q.key == req_q.key);
  assign scan_done  = (scan_idx >= fill_q) && !cmp_vld;
  assign is_add     = (req_q.kind == KIND_ADD);
  assign full       = (fill_q == SPB_F);
  assign do_insert  = is_add && !hit && !full;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      CLEAR:   if (clr_idx == {BUCKET_BITS{1'b1}}) state_next = IDLE;
      IDLE:    if (req_valid) state_next = FILL;
      FILL:    state_next = SCAN;
      SCAN:    if (cmp_hit || scan_done) state_next = RESOLVE;
      RESOLVE: if (load) state_next = IDLE;
      default: state_next = CLEAR;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    req_stall  = 1'b1;
    fill_re    = 1'b0;
    fill_we    = 1'b0;
    fill_waddr = bucket;
    fill_wdata = fill_q + FILL_W'(1);
    slot_re    = 1'b0;
    slot_we    = 1'b0;
    slot_waddr = hit ? hit_addr : base + ADDR_W'(fill_q);
    slot_wdata = '0;
    load       = 1'b0;
    unique case (state)
      CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_idx;
        fill_wdata = '0;
      end
      IDLE:    req_stall = 1'b0;
      FILL:    fill_re = 1'b1;
      SCAN:    slot_re = (scan_idx < fill_q) && !cmp_hit;
      RESOLVE: begin
        load    = !rsp_valid || !rsp_stall;
        fill_we = load && do_insert;
        slot_we = load && is_add && (hit || !full);
      end
      default: ;
    endcase
    slot_wdata.key = req_q.key;
    if (hit) begin
      slot_wdata.count_a = hit_data.count_a + req_q.inc_a;
      slot_wdata.count_b = hit_data.count_b + req_q.inc_b;
      slot_wdata.count_c = hit_data.count_c + req_q.inc_c;
    end else begin
      slot_wdata.count_a = req_q.inc_a;
      slot_wdata.count_b = req_q.inc_b;
      slot_wdata.count_c = req_q.inc_c;
    end
  end

  // Result
  always_comb begin
    rsp_next             = '0;
    rsp_next.adds_seen   = add_total + (is_add ? 64'd1 : 64'd0);
    rsp_next.keys_stored = unique_total + (do_insert ? 64'd1 : 64'd0);
    priority if (is_add && hit) begin
      rsp_next.status  = ST_MERGED;
      rsp_next.value_a = slot_wdata.count_a;
      rsp_next.value_b = slot_wdata.count_b;
      rsp_next.value_c = slot_wdata.count_c;
    end else if (is_add && full) begin
      rsp_next.status = ST_FULL;
    end else if (is_add) begin
      rsp_next.status  = ST_INSERTED;
      rsp_next.value_a = slot_wdata.count_a;
      rsp_next.value_b = slot_wdata.count_b;
      rsp_next.value_c = slot_wdata.count_c;
    end else if (hit) begin
      rsp_next.status  = ST_FOUND;
      rsp_next.value_a = hit_data.count_a;
      rsp_next.value_b = hit_data.count_b;
      rsp_next.value_c = hit_data.count_c;
    end else begin
      rsp_next.status = ST_MISSING;
    end
  end

  // Bucket fill memory
  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
    if (fill_re) fill_q <= fill_mem[bucket];
  end

  // Slot memory
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (slot_re) slot_q <= slot_mem[slot_raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= CLEAR;
      clr_idx      <= '0;
      cmp_vld      <= 1'b0;
      hit          <= 1'b0;
      add_total    <= '0;
      unique_total <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == CLEAR) clr_idx <= clr_idx + BUCKET_BITS'(1);
      if (state == FILL) begin
        cmp_vld <= 1'b0;
        hit     <= 1'b0;
      end else if (state == SCAN) begin
        cmp_vld <= slot_re;
        if (cmp_hit) hit <= 1'b1;
      end
      if (load) begin
        add_total    <= rsp_next.adds_seen;
        unique_total <= rsp_next.keys_stored;
        rsp_valid    <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == IDLE && req_valid) req_q <= req_data;
    if (state == FILL) begin
      base     <= ADDR_W'(bucket) * SPB_A;
      scan_idx <= '0;
    end
    if (slot_re) begin
      scan_idx <= scan_idx + FILL_W'(1);
      cmp_addr <= slot_raddr;
    end
    if (state == SCAN && cmp_hit) begin
      hit_addr <= cmp_addr;
      hit_data <= slot_q;
    end
    if (load) rsp_q <= rsp_next;
  end

  assign rsp_data = rsp_q;

endmodule
